// File: design/rtccal_pkg.sv
// ----------------------------------------------------------------------------
// rtccal_pkg
// Shared types and constants for the millisecond-driven clock and calendar.
// ----------------------------------------------------------------------------
`default_nettype none

package rtccal_pkg;

	localparam int TICKS_PER_SECOND = 1000;
	localparam int TICKS_PER_HALF   = 500;
	localparam int INTERVAL_WRAP    = 30000;

	localparam int MS_W   = $clog2(TICKS_PER_SECOND);
	localparam int HALF_W = (TICKS_PER_HALF > 1) ? $clog2(TICKS_PER_HALF) : 1;
	localparam int IVL_W  = $clog2(INTERVAL_WRAP);

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_LOAD  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	typedef struct packed {
		logic [1:0] operation;
		logic [4:0] load_hour;
		logic [5:0] load_minute;
		logic [5:0] load_second;
		logic [4:0] load_day;
		logic [3:0] load_month;
		logic [6:0] load_year;
	} in_word_t;

	typedef struct packed {
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [4:0]  day;
		logic [3:0]  month;
		logic [6:0]  year;
		logic        half_second;
		logic [14:0] interval_ticks;
	} out_word_t;

	typedef struct packed {
		logic     accept;
		in_word_t word;
	} step_ctl_t;

endpackage

`default_nettype wire

// File: design/rtccal_clock.sv
// ----------------------------------------------------------------------------
// rtccal_clock
// Time, date and interval state with combinational next-state logic.
// ----------------------------------------------------------------------------
`default_nettype none

module rtccal_clock (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire rtccal_pkg::step_ctl_t  ctl,
	output      rtccal_pkg::out_word_t  nxt
);

	logic [rtccal_pkg::MS_W-1:0]   ms_q,   ms_d;
	logic [rtccal_pkg::HALF_W-1:0] half_q, half_d;
	logic                          flag_q, flag_d;
	logic [5:0]                    sec_q,  sec_d;
	logic [5:0]                    min_q,  min_d;
	logic [4:0]                    hour_q, hour_d;
	logic [4:0]                    day_q,  day_d;
	logic [3:0]                    mon_q,  mon_d;
	logic [6:0]                    year_q, year_d;
	logic [rtccal_pkg::IVL_W-1:0]  ivl_q,  ivl_d;

	logic [rtccal_pkg::MS_W:0]     ms_inc;
	logic [rtccal_pkg::IVL_W:0]    ivl_inc;
	logic                          ms_wrap;
	logic                          day_end;
	logic [4:0]                    day_adv;
	logic [3:0]                    mon_adv;
	logic [6:0]                    year_adv;
	logic                          month_end;

	assign ms_inc  = {1'b0, ms_q} + (rtccal_pkg::MS_W+1)'(1);
	assign ivl_inc = {1'b0, ivl_q} + (rtccal_pkg::IVL_W+1)'(1);
	assign ms_wrap = (ms_inc >= (rtccal_pkg::MS_W+1)'(rtccal_pkg::TICKS_PER_SECOND));
	assign day_end = (sec_q >= 6'd59) && (min_q >= 6'd59) && (hour_q >= 5'd23);

	// date advance at midnight
	always_comb begin
		month_end = 1'b0;
		if (day_q < 5'd28) begin
			month_end = 1'b0;
		end else if (mon_q == 4'd2) begin
			month_end = !((year_q[1:0] == 2'b00) && (day_q == 5'd28));
		end else if (mon_q inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
			month_end = (day_q >= 5'd30);
		end else begin
			month_end = (day_q >= 5'd31);
		end
		day_adv  = day_q + 5'd1;
		mon_adv  = mon_q;
		year_adv = year_q;
		if (month_end) begin
			day_adv = 5'd1;
			if (mon_q >= 4'd12) begin
				mon_adv  = 4'd1;
				year_adv = (year_q >= 7'd99) ? 7'd0 : year_q + 7'd1;
			end else begin
				mon_adv = mon_q + 4'd1;
			end
		end
	end

	always_comb begin
		ms_d   = ms_q;
		half_d = half_q;
		flag_d = flag_q;
		sec_d  = sec_q;
		min_d  = min_q;
		hour_d = hour_q;
		day_d  = day_q;
		mon_d  = mon_q;
		year_d = year_q;
		ivl_d  = ivl_q;
		case (ctl.word.operation)
			rtccal_pkg::OP_TICK: begin
				ms_d  = ms_wrap ? '0 : ms_inc[rtccal_pkg::MS_W-1:0];
				ivl_d = (ivl_inc >= (rtccal_pkg::IVL_W+1)'(rtccal_pkg::INTERVAL_WRAP)) ?
					'0 : ivl_inc[rtccal_pkg::IVL_W-1:0];
				if (ms_wrap || (half_q ==
						(rtccal_pkg::HALF_W)'(rtccal_pkg::TICKS_PER_HALF - 1))) begin
					half_d = '0;
				end else begin
					half_d = half_q + (rtccal_pkg::HALF_W)'(1);
				end
				if (half_d == '0) begin
					flag_d = !flag_q;
				end
				if (ms_wrap) begin
					if (sec_q < 6'd59) begin
						sec_d = sec_q + 6'd1;
					end else begin
						sec_d = 6'd0;
						if (min_q < 6'd59) begin
							min_d = min_q + 6'd1;
						end else begin
							min_d = 6'd0;
							if (hour_q < 5'd23) begin
								hour_d = hour_q + 5'd1;
							end else begin
								hour_d = 5'd0;
							end
						end
					end
					if (day_end) begin
						day_d  = day_adv;
						mon_d  = mon_adv;
						year_d = year_adv;
					end
				end
			end
			rtccal_pkg::OP_LOAD: begin
				hour_d = ctl.word.load_hour;
				min_d  = ctl.word.load_minute;
				sec_d  = ctl.word.load_second;
				day_d  = ctl.word.load_day;
				mon_d  = ctl.word.load_month;
				year_d = ctl.word.load_year;
			end
			rtccal_pkg::OP_CLEAR: begin
				ivl_d = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_q   <= '0;
			half_q <= '0;
			flag_q <= 1'b0;
			sec_q  <= 6'd0;
			min_q  <= 6'd0;
			hour_q <= 5'd0;
			day_q  <= 5'd1;
			mon_q  <= 4'd1;
			year_q <= 7'd0;
			ivl_q  <= '0;
		end else if (ctl.accept) begin
			ms_q   <= ms_d;
			half_q <= half_d;
			flag_q <= flag_d;
			sec_q  <= sec_d;
			min_q  <= min_d;
			hour_q <= hour_d;
			day_q  <= day_d;
			mon_q  <= mon_d;
			year_q <= year_d;
			ivl_q  <= ivl_d;
		end
	end

	always_comb begin
		nxt.hour           = hour_d;
		nxt.minute         = min_d;
		nxt.second         = sec_d;
		nxt.day            = day_d;
		nxt.month          = mon_d;
		nxt.year           = year_d;
		nxt.half_second    = flag_d;
		nxt.interval_ticks = 15'(ivl_d);
	end

	a_ms_range: assert property (@(posedge clk) disable iff (!arst_n)
		ms_q < (rtccal_pkg::MS_W)'(rtccal_pkg::TICKS_PER_SECOND))
		else $error("ms counter out of range");

	a_ivl_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, ivl_q} < (rtccal_pkg::IVL_W+1)'(rtccal_pkg::INTERVAL_WRAP))
		else $error("interval counter out of range");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.accept && (ctl.word.operation == rtccal_pkg::OP_CLEAR) |=> (ivl_q == '0))
		else $error("interval clear lost");

	a_hold_sub: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.accept && (ctl.word.operation != rtccal_pkg::OP_TICK)
		|=> $stable(ms_q) && $stable(half_q) && $stable(flag_q))
		else $error("sub-second state changed without a tick");

	a_half_sync: assert property (@(posedge clk) disable iff (!arst_n)
		(ms_q == '0) |-> (half_q == '0))
		else $error("half counter out of step with ms counter");

endmodule

`default_nettype wire

// File: design/rtc_calendar_tick_core.sv
// ----------------------------------------------------------------------------
// rtc_calendar_tick_core
// Millisecond-tick real-time clock with calendar and interval counter.
// ----------------------------------------------------------------------------
// The result word is registered and appears in the cycle after its request word is taken.
// Throughput: one request word per cycle; the input stalls only while a result
// word is held under a stall.
// Reset: 00:00:00 on day 1, month 1, year 0, counters and toggle flag cleared;
// the result register comes up empty.
`default_nettype none

module rtc_calendar_tick_core (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  req_valid,
	output      logic                  req_stall,
	input  wire rtccal_pkg::in_word_t  req_word,
	output      logic                  rsp_valid,
	input  wire logic                  rsp_stall,
	output      rtccal_pkg::out_word_t rsp_word
);

	rtccal_pkg::step_ctl_t ctl;
	rtccal_pkg::out_word_t nxt;
	logic                  rsp_valid_q;
	rtccal_pkg::out_word_t rsp_word_q;

	assign req_stall = rsp_valid_q && rsp_stall;
	assign ctl       = {req_valid && !req_stall, req_word};

	rtccal_clock u_clock (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.nxt    (nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (!req_stall) begin
			rsp_valid_q <= ctl.accept;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			rsp_word_q <= nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_word_q;

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - clock and calendar core testbench
// Drives tick, load, clear and unused operation words into the core and
// checks every result word against an in-bench calendar predictor. Each
// round loads a time close to a rollover, out-of-range fields included, and
// ticks; the last round ticks past the second boundary so the carry chain
// runs from a loaded time.
// Both sides pause at random; the receiver also holds off for a long
// stretch to back up the core, and the sender once waits for all results.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int         CLK_PERIOD  = 10;
	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam int         ROUNDS      = 40;
	localparam int         SHORT_MIN   = 10;
	localparam int         SHORT_MAX   = 20;
	localparam int         PAUSE_ROUND = 10;
	localparam int         HOLD_AFTER  = 600;
	localparam int         HOLD_CYCLES = 300;
	localparam int         QUIET_LIMIT = 2000;

	class calendar_scoreboard;
		logic [rtccal_pkg::MS_W-1:0]  ms_count;
		logic                         half_flag;
		logic [4:0]                   hour;
		logic [5:0]                   minute;
		logic [5:0]                   second;
		logic [4:0]                   day;
		logic [3:0]                   month;
		logic [6:0]                   year;
		logic [rtccal_pkg::IVL_W-1:0] interval;
		rtccal_pkg::out_word_t        expected_q[$];
		int unsigned      mismatches, words_checked;
		int unsigned      ticks, loads, clears, unused_ops;
		int unsigned      second_carries, day_changes, month_changes, year_wraps;
		int unsigned      interval_wraps, half_flips;

		function new();
			ms_count  = '0;
			half_flag = 1'b0;
			hour      = '0;
			minute    = '0;
			second    = '0;
			day       = 5'd1;
			month     = 4'd1;
			year      = '0;
			interval  = '0;
		endfunction

		function void roll_month();
			day = 5'd1;
			month_changes++;
			if (month >= 12) begin
				month = 4'd1;
				if (year >= 99) begin
					year = 7'd0;
					year_wraps++;
				end else
					year = year + 7'd1;
			end else
				month = month + 4'd1;
		endfunction

		function void note_request(rtccal_pkg::in_word_t w);
			int                    next_ms, next_ivl;
			rtccal_pkg::out_word_t want;
			case (w.operation)
			rtccal_pkg::OP_TICK: begin
				ticks++;
				next_ms = int'(ms_count) + 1;
				if (next_ms >= rtccal_pkg::TICKS_PER_SECOND)
					next_ms = 0;
				ms_count = (rtccal_pkg::MS_W)'(next_ms);
				next_ivl = int'(interval) + 1;
				if (next_ivl >= rtccal_pkg::INTERVAL_WRAP) begin
					next_ivl = 0;
					interval_wraps++;
				end
				interval = (rtccal_pkg::IVL_W)'(next_ivl);
				if (next_ms % rtccal_pkg::TICKS_PER_HALF == 0) begin
					half_flag = ~half_flag;
					half_flips++;
				end
				if (next_ms == 0) begin
					second_carries++;
					if (second < 59)
						second++;
					else begin
						second = '0;
						if (minute < 59)
							minute++;
						else begin
							minute = '0;
							if (hour < 23)
								hour++;
							else begin
								hour = '0;
								day_changes++;
								if (day < 28)
									day++;
								else if (month == 2) begin
									if (year % 4 == 0 && day == 28)
										day++;
									else
										roll_month();
								end else if (month inside {4, 6, 9, 11}) begin
									if (day < 30)
										day++;
									else
										roll_month();
								end else if (day < 31)
									day++;
								else
									roll_month();
							end
						end
					end
				end
			end
			rtccal_pkg::OP_LOAD: begin
				loads++;
				hour   = w.load_hour;
				minute = w.load_minute;
				second = w.load_second;
				day    = w.load_day;
				month  = w.load_month;
				year   = w.load_year;
			end
			rtccal_pkg::OP_CLEAR: begin
				clears++;
				interval = '0;
			end
			default: begin
				unused_ops++;
			end
			endcase
			want.hour           = hour;
			want.minute         = minute;
			want.second         = second;
			want.day            = day;
			want.month          = month;
			want.year           = year;
			want.half_second    = half_flag;
			want.interval_ticks = interval;
			expected_q.push_back(want);
		endfunction

		function string show(rtccal_pkg::out_word_t w);
			return $sformatf("%0d:%0d:%0d %0d/%0d/%0d half=%0b ivl=%0d", w.hour, w.minute,
				w.second, w.day, w.month, w.year, w.half_second, w.interval_ticks);
		endfunction

		function void check_result(rtccal_pkg::out_word_t got);
			rtccal_pkg::out_word_t want;
			bit                    bad;
			words_checked++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result word %s with nothing expected", $time, show(got));
				return;
			end
			want = expected_q.pop_front();
			bad = (got.hour !== want.hour) || (got.minute !== want.minute) ||
				(got.second !== want.second) || (got.day !== want.day) ||
				(got.month !== want.month) || (got.year !== want.year) ||
				(got.half_second !== want.half_second) ||
				(got.interval_ticks !== want.interval_ticks);
			if (bad) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result word %0d: expected %s, got %s", $time,
						words_checked, show(want), show(got));
			end
		endfunction
	endclass

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  req_valid = 1'b0;
	rtccal_pkg::in_word_t  req_word  = '0;
	logic                  rsp_stall = 1'b0;
	logic                  req_stall;
	logic                  rsp_valid;
	rtccal_pkg::out_word_t rsp_word;

	calendar_scoreboard   sb;
	rtccal_pkg::in_word_t boundary_loads[16];
	int unsigned          quiet_cycles = 0;
	int unsigned          stall_left   = 0;
	int unsigned          calm_left    = 0;
	bit                   hold_done    = 1'b0;

	rtc_calendar_tick_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_word (req_word),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_word (rsp_word)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		if (roll < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic rtccal_pkg::in_word_t make_word(logic [1:0] op, int h, int m, int s,
		int d, int mo, int y);
		rtccal_pkg::in_word_t w;
		w.operation   = op;
		w.load_hour   = 5'(h);
		w.load_minute = 6'(m);
		w.load_second = 6'(s);
		w.load_day    = 5'(d);
		w.load_month  = 4'(mo);
		w.load_year   = 7'(y);
		return w;
	endfunction

	function automatic rtccal_pkg::in_word_t random_word(logic [1:0] op);
		logic [63:0]          bits;
		rtccal_pkg::in_word_t w;
		bits = {$urandom, $urandom};
		w = bits[$bits(rtccal_pkg::in_word_t)-1:0];
		w.operation = op;
		return w;
	endfunction

	// bias toward the last second of a day at the end of a month
	function automatic rtccal_pkg::in_word_t calendar_load();
		rtccal_pkg::in_word_t w;
		int unsigned          roll;
		w = random_word(rtccal_pkg::OP_LOAD);
		roll = $urandom_range(0, 9);
		if (roll < 7)
			w.load_hour = 5'd23;
		else if (roll == 7)
			w.load_hour = 5'd22;
		if ($urandom_range(0, 3) != 0)
			w.load_minute = 6'd59;
		if ($urandom_range(0, 4) != 0)
			w.load_second = 6'd59;
		roll = $urandom_range(0, 9);
		if (roll < 5)
			w.load_day = 5'($urandom_range(27, 31));
		else if (roll == 5)
			w.load_day = 5'd0;
		if ($urandom_range(0, 4) < 3)
			w.load_month = 4'($urandom_range(1, 12));
		roll = $urandom_range(0, 19);
		if (roll < 8)
			w.load_year = 7'(4 * $urandom_range(0, 24));
		else if (roll < 11)
			w.load_year = 7'd99;
		return w;
	endfunction

	task automatic offer(rtccal_pkg::in_word_t w, bit pace);
		int unsigned gap;
		gap = pace ? pick_gap() : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_word  <= w;
		do
			@(posedge clk);
		while (req_stall);
		sb.note_request(w);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.expected_q.size() != 0);
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_result(rsp_word);
	end

	always @(posedge clk) begin
		if (!arst_n)
			rsp_stall <= 1'b0;
		else if (!hold_done && sb.words_checked >= HOLD_AFTER) begin
			hold_done = 1'b1;
			stall_left = HOLD_CYCLES - 1;
			rsp_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
			if (calm_left > 0)
				calm_left--;
			else if ($urandom_range(0, 499) == 0)
				calm_left = $urandom_range(200, 800);
			else if ($urandom_range(0, 3) == 0)
				stall_left = pick_gap();
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles <= 0;
		else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
			$display("tb_top NOT OK");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		bit          pace, clears_ok;
		int          run;
		int unsigned roll;

		sb = new();
		boundary_loads = '{
			make_word(rtccal_pkg::OP_LOAD, 23, 59, 59, 31, 12, 99),
			make_word(rtccal_pkg::OP_LOAD, 23, 59, 59, 28, 2, 24),
			make_word(rtccal_pkg::OP_LOAD, 23, 59, 59, 29, 2, 24),
			make_word(rtccal_pkg::OP_LOAD, 23, 59, 59, 28, 2, 23),
			make_word(rtccal_pkg::OP_LOAD, 23, 59, 59, 30, 4, 50),
			make_word(rtccal_pkg::OP_LOAD, 23, 59, 59, 29, 11, 7),
			make_word(rtccal_pkg::OP_LOAD, 23, 59, 59, 30, 1, 10),
			make_word(rtccal_pkg::OP_LOAD, 31, 63, 63, 0, 0, 127),
			make_word(rtccal_pkg::OP_LOAD, 31, 63, 63, 31, 15, 127),
			make_word(rtccal_pkg::OP_LOAD, 23, 59, 59, 31, 0, 5),
			make_word(rtccal_pkg::OP_LOAD, 22, 59, 59, 27, 2, 1),
			make_word(rtccal_pkg::OP_LOAD, 23, 58, 59, 30, 9, 60),
			make_word(rtccal_pkg::OP_LOAD, 23, 59, 59, 29, 2, 23),
			make_word(rtccal_pkg::OP_LOAD, 23, 59, 59, 31, 6, 3),
			make_word(rtccal_pkg::OP_LOAD, 12, 30, 58, 15, 8, 40),
			make_word(rtccal_pkg::OP_LOAD, 23, 59, 59, 31, 2, 0)
		};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		offer(make_word(OP_UNUSED, 31, 63, 63, 31, 15, 127), 1'b1);
		offer(make_word(rtccal_pkg::OP_TICK, 31, 63, 63, 31, 15, 127), 1'b1);
		offer(make_word(rtccal_pkg::OP_CLEAR, 31, 63, 63, 31, 15, 127), 1'b1);
		offer(make_word(rtccal_pkg::OP_LOAD, 0, 0, 0, 0, 0, 0), 1'b1);
		offer(make_word(rtccal_pkg::OP_TICK, 0, 0, 0, 0, 0, 0), 1'b1);
		offer(make_word(rtccal_pkg::OP_LOAD, 31, 63, 63, 31, 15, 127), 1'b1);
		offer(make_word(OP_UNUSED, 0, 0, 0, 0, 0, 0), 1'b1);
		offer(make_word(rtccal_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0), 1'b1);
		offer(make_word(rtccal_pkg::OP_LOAD, 12, 34, 56, 29, 2, 24), 1'b1);
		offer(make_word(rtccal_pkg::OP_TICK, 12, 34, 56, 29, 2, 24), 1'b1);

		// load near a rollover and tick; the last round ticks past the second boundary
		for (int r = 0; r < ROUNDS; r++) begin
			pace      = (r % 4 != 2);
			clears_ok = (r < 4) || (r >= ROUNDS - 2);
			if (r == PAUSE_ROUND)
				drain();
			if (r == ROUNDS - 1) begin
				offer(boundary_loads[$urandom_range(0, $size(boundary_loads) - 1)], pace);
				run = rtccal_pkg::TICKS_PER_SECOND - int'(sb.ms_count) +
					int'($urandom_range(0, 40));
			end else begin
				offer((r < $size(boundary_loads)) ? boundary_loads[r] : calendar_load(),
					pace);
				run = int'($urandom_range(SHORT_MIN, SHORT_MAX));
			end
			for (int i = 0; i < run; i++) begin
				roll = $urandom_range(0, 299);
				if (roll < 5)
					offer(random_word(OP_UNUSED), pace);
				else if (roll < 8 && clears_ok)
					offer(random_word(rtccal_pkg::OP_CLEAR), pace);
				else if (roll == 8)
					offer(calendar_load(), pace);
				offer(random_word(rtccal_pkg::OP_TICK), pace);
			end
		end

		drain();
		repeat (4) @(posedge clk);

		$display("covered %0d ticks, %0d loads, %0d clears, %0d unused; %0d checked",
			sb.ticks, sb.loads, sb.clears, sb.unused_ops, sb.words_checked);
		$display("carries: %0d seconds, %0d days, %0d months, %0d years, %0d intervals",
			sb.second_carries, sb.day_changes, sb.month_changes, sb.year_wraps,
			sb.interval_wraps);
		if (sb.mismatches == 0 && sb.expected_q.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

// File: filelist.f
design/rtccal_pkg.sv
design/rtccal_clock.sv
design/rtc_calendar_tick_core.sv
verif/tb_top.sv
